[design/fpdt_pkg.sv]
package fpdt_pkg;

   localparam int INT_DIGITS = 5;
   localparam int PC_WIDTH   = 3;

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_DOT   = 7'h2E;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;

   // reciprocal of ten for the integer digit split: q = (x * RECIP_TEN) >> RECIP_SHIFT
   localparam logic [15:0] RECIP_TEN   = 16'd52429;
   localparam int          RECIP_SHIFT = 19;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_FRAC,
      OP_IDIV,
      OP_SIGN,
      OP_INT,
      OP_DOT,
      OP_FRACOUT,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_MORE,
      COND_NO_DOT
   } cond_type;

   typedef struct packed {
      op_type                op;
      cond_type              cond;
      logic [PC_WIDTH-1:0]   target;
   } uword_type;

   typedef struct packed {
      logic more;
      logic no_dot;
      logic stall;
   } status_type;

   localparam logic [PC_WIDTH-1:0] PC_IDLE    = 3'd0;
   localparam logic [PC_WIDTH-1:0] PC_FRAC    = 3'd1;
   localparam logic [PC_WIDTH-1:0] PC_IDIV    = 3'd2;
   localparam logic [PC_WIDTH-1:0] PC_SIGN    = 3'd3;
   localparam logic [PC_WIDTH-1:0] PC_INT     = 3'd4;
   localparam logic [PC_WIDTH-1:0] PC_DOT     = 3'd5;
   localparam logic [PC_WIDTH-1:0] PC_FRACOUT = 3'd6;
   localparam logic [PC_WIDTH-1:0] PC_WRAP    = 3'd7;

   // Control store: a jump is taken when its condition holds, else the step advances; a stall holds the step.
   function automatic uword_type rom_word(input logic [PC_WIDTH-1:0] pc);
      uword_type w;
      case (pc)
         PC_IDLE:    w = '{op: OP_IDLE,    cond: COND_NO_REQ, target: PC_IDLE};
         PC_FRAC:    w = '{op: OP_FRAC,    cond: COND_MORE,   target: PC_FRAC};
         PC_IDIV:    w = '{op: OP_IDIV,    cond: COND_MORE,   target: PC_IDIV};
         PC_SIGN:    w = '{op: OP_SIGN,    cond: COND_NEVER,  target: PC_IDLE};
         PC_INT:     w = '{op: OP_INT,     cond: COND_MORE,   target: PC_INT};
         PC_DOT:     w = '{op: OP_DOT,     cond: COND_NO_DOT, target: PC_IDLE};
         PC_FRACOUT: w = '{op: OP_FRACOUT, cond: COND_MORE,   target: PC_FRACOUT};
         default:    w = '{op: OP_NOP,     cond: COND_ALWAYS, target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

[design/fpdt_sequencer.sv]
module fpdt_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  fpdt_pkg::status_type  status,
   output fpdt_pkg::op_type      op
);

   logic [fpdt_pkg::PC_WIDTH-1:0] pc_ff;
   logic [fpdt_pkg::PC_WIDTH-1:0] pc_in;
   fpdt_pkg::uword_type           word;
   logic                          take;

   assign word = fpdt_pkg::rom_word(pc_ff);
   assign op   = word.op;

   always_comb begin
      case (word.cond)
         fpdt_pkg::COND_NEVER:  take = 1'b0;
         fpdt_pkg::COND_ALWAYS: take = 1'b1;
         fpdt_pkg::COND_NO_REQ: take = !req_valid;
         fpdt_pkg::COND_MORE:   take = status.more;
         fpdt_pkg::COND_NO_DOT: take = status.no_dot;
         default:               take = 1'b0;
      endcase
   end

   always_comb begin
      if (status.stall) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + fpdt_pkg::PC_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= fpdt_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[design/fpdt_datapath.sv]
module fpdt_datapath #(
   parameter int FRACTION_DIGITS = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data,
   input  fpdt_pkg::op_type      op,
   input  logic                  req_valid,
   input  logic signed [15:0]    req_fixed_value,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [6:0]            rsp_text_char,
   output logic                  rsp_last_char,
   output fpdt_pkg::status_type  status
);

   localparam int KW = $clog2(FRACTION_DIGITS + 1);
   localparam int IW = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
   localparam logic [KW-1:0] K_LAST = KW'(FRACTION_DIGITS - 1);

   logic [3:0]  fbits_ff;
   logic        neg_ff;
   logic [15:0] ipart_ff;
   logic [14:0] frac_ff;
   logic [2:0]  nd_ff;
   logic [KW-1:0] k_ff;
   logic [KW-1:0] keep_ff;
   logic [3:0]  istack_ff [fpdt_pkg::INT_DIGITS];
   logic [3:0]  fdig_ff [FRACTION_DIGITS];

   logic        out_valid_ff;
   logic [6:0]  out_char_ff;
   logic        out_last_ff;

   logic [16:0] mask_wide;
   logic [14:0] mask;
   logic [15:0] mag;
   logic [31:0] qprod;
   logic [15:0] quot;
   logic [3:0]  rem;
   logic [18:0] prod10;
   logic [3:0]  fdigit;
   logic [2:0]  nd_top;

   logic        emit;
   logic [6:0]  emit_char;
   logic        emit_last;
   logic        stall;
   logic        go;
   logic        load;
   logic        more;

   assign mask_wide = (17'd1 << fbits_ff) - 17'd1;
   assign mask      = mask_wide[14:0];
   assign mag       = req_fixed_value[15] ? 16'(-req_fixed_value) : 16'(req_fixed_value);

   assign qprod  = ipart_ff * fpdt_pkg::RECIP_TEN;
   assign quot   = 16'(qprod >> fpdt_pkg::RECIP_SHIFT);
   assign rem    = 4'(ipart_ff - ((quot << 3) + (quot << 1)));

   assign prod10 = (19'(frac_ff) << 3) + (19'(frac_ff) << 1);
   assign fdigit = 4'(prod10 >> fbits_ff);

   assign nd_top = nd_ff - 3'd1;

   always_comb begin
      emit      = 1'b0;
      emit_char = fpdt_pkg::CHAR_ZERO;
      emit_last = 1'b0;
      case (op)
         fpdt_pkg::OP_SIGN: begin
            emit      = neg_ff;
            emit_char = fpdt_pkg::CHAR_MINUS;
         end
         fpdt_pkg::OP_INT: begin
            emit      = 1'b1;
            emit_char = fpdt_pkg::CHAR_ZERO + 7'(istack_ff[nd_top]);
            emit_last = (nd_ff == 3'd1) && (keep_ff == '0);
         end
         fpdt_pkg::OP_DOT: begin
            emit      = (keep_ff != '0);
            emit_char = fpdt_pkg::CHAR_DOT;
         end
         fpdt_pkg::OP_FRACOUT: begin
            emit      = 1'b1;
            emit_char = fpdt_pkg::CHAR_ZERO + 7'(fdig_ff[k_ff[IW-1:0]]);
            emit_last = (k_ff == keep_ff - KW'(1));
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // hold the sequencer while a character waits for a free output slot
   assign stall = emit && out_valid_ff && !rsp_ready;
   assign go    = !stall;
   assign load  = (op == fpdt_pkg::OP_IDLE) && req_valid;

   always_comb begin
      case (op)
         fpdt_pkg::OP_FRAC:    more = (k_ff != K_LAST);
         fpdt_pkg::OP_IDIV:    more = (quot != 16'd0);
         fpdt_pkg::OP_INT:     more = (nd_ff != 3'd1);
         fpdt_pkg::OP_FRACOUT: more = (k_ff != keep_ff - KW'(1));
         default:              more = 1'b0;
      endcase
   end

   assign status = '{more: more, no_dot: (keep_ff == '0), stall: stall};

   always_ff @(posedge clock) begin
      if (reset) begin
         fbits_ff <= 4'd8;
      end else if (csr_wr_en) begin
         fbits_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff  <= 1'b0;
         nd_ff   <= 3'd0;
         k_ff    <= '0;
         keep_ff <= '0;
      end else if (load) begin
         neg_ff  <= req_fixed_value[15];
         nd_ff   <= 3'd0;
         k_ff    <= '0;
         keep_ff <= '0;
      end else if (go) begin
         case (op)
            fpdt_pkg::OP_FRAC: begin
               if (fdigit != 4'd0) begin
                  keep_ff <= k_ff + KW'(1);
               end
               // rewind for the output pass
               k_ff <= (k_ff == K_LAST) ? '0 : k_ff + KW'(1);
            end
            fpdt_pkg::OP_IDIV: begin
               nd_ff <= nd_ff + 3'd1;
            end
            fpdt_pkg::OP_INT: begin
               nd_ff <= nd_top;
            end
            fpdt_pkg::OP_FRACOUT: begin
               k_ff <= k_ff + KW'(1);
            end
            default: begin
               k_ff <= k_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ipart_ff <= mag >> fbits_ff;
         frac_ff  <= mag[14:0] & mask;
      end else if (op == fpdt_pkg::OP_FRAC) begin
         frac_ff                <= prod10[14:0] & mask;
         fdig_ff[k_ff[IW-1:0]]  <= fdigit;
      end else if (op == fpdt_pkg::OP_IDIV) begin
         ipart_ff          <= quot;
         istack_ff[nd_ff]  <= rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit && go) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && go) begin
         out_char_ff <= emit_char;
         out_last_ff <= emit_last;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_text_char = out_char_ff;
   assign rsp_last_char = out_last_ff;

endmodule

[design/fixed_point_to_decimal_text.sv]
// One value at a time: a transaction is taken when the step counter is at its idle step.
// Steps: FRACTION_DIGITS fraction steps, one per integer digit (1 to 5), a sign step, one per
// integer digit again, a point step, then one per fraction digit and a return step if a point prints.
// The first character is registered in the sign step if negative, else in the first integer step.
// A new value is taken only once the last step has returned to idle; an output stall holds the
// step counter until the output slot frees.
// Synchronous active-high reset: step counter idle, output empty, fraction_bits = 8.
module fixed_point_to_decimal_text #(
   parameter int FRACTION_DIGITS = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [3:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_fixed_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_text_char,
   output logic               rsp_last_char
);

   fpdt_pkg::op_type     op;
   fpdt_pkg::status_type status;

   fpdt_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .op        (op)
   );

   fpdt_datapath #(
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .op              (op),
      .req_valid       (req_valid),
      .req_fixed_value (req_fixed_value),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char),
      .status          (status)
   );

   assign req_ready = (op == fpdt_pkg::OP_IDLE) && !reset;

endmodule
